### rtl/core/acpt_pkg.sv
// Shared types and constants for the angle crossing pulse timer.
`default_nettype none

package acpt_pkg;

	// Field widths
	localparam int HEAD_W     = 16;
	localparam int TIME_W     = 48;
	localparam int DELAY_W    = 20;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 1;

	// Interpolation widths: |step| and |offset| stay below a quarter turn
	localparam int MAG_W      = 14;
	localparam int HALF_W     = TIME_W / 2;
	localparam int PP_W       = MAG_W + HALF_W;
	localparam int PROD_W     = MAG_W + TIME_W;
	localparam int DIV_CNT_W  = $clog2(TIME_W);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TIME_W - 1);
	localparam logic signed [HEAD_W-1:0] QUARTER_TURN = 16'sd16384;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BEACON = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV_INIT,
		ST_DIV,
		ST_SUM_BASE,
		ST_SUM_DELAY,
		ST_DUE,
		ST_SEND0,
		ST_SEND1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic take_pend;
		logic store_prev;
		logic mul_lo;
		logic mul_hi;
		logic div_init;
		logic div_step;
		logic sum_base;
		logic sum_delay;
		logic take_new;
		logic out_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pend_due;
		logic hit;
		logic due_now;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/acpt_ctrl.sv
// Sequencing controller for the angle crossing pulse timer.
`default_nettype none

module acpt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               last,
	input  wire acpt_pkg::sts_t sts,
	output acpt_pkg::cmd_t     cmd
);
	import acpt_pkg::*;

	state_t state_q, state_d;
	logic   emit0_q, emit0_d;
	logic   emit1_q, emit1_d;

	// State and emit flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			emit0_q <= 1'b0;
			emit1_q <= 1'b0;
		end else begin
			state_q <= state_d;
			emit0_q <= emit0_d;
			emit1_q <= emit1_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		emit0_d   = emit0_q;
		emit1_d   = emit1_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval      = 1'b1;
				cmd.take_pend = sts.pend_due;
				emit0_d       = sts.pend_due;
				emit1_d       = 1'b0;
				if (sts.hit) begin
					state_d = ST_MUL_LO;
				end else begin
					cmd.store_prev = 1'b1;
					state_d        = sts.pend_due ? ST_SEND0 : ST_IDLE;
				end
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SUM_BASE;
				end
			end
			ST_SUM_BASE: begin
				cmd.sum_base = 1'b1;
				state_d      = ST_SUM_DELAY;
			end
			ST_SUM_DELAY: begin
				cmd.sum_delay = 1'b1;
				state_d       = ST_DUE;
			end
			ST_DUE: begin
				cmd.take_new   = sts.due_now;
				cmd.store_prev = 1'b1;
				emit1_d        = sts.due_now;
				if (emit0_q) begin
					state_d = ST_SEND0;
				end else if (sts.due_now) begin
					state_d = ST_SEND1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEND0: begin
				out_valid   = 1'b1;
				cmd.out_sel = 1'b0;
				last        = !emit1_q;
				if (out_ready) begin
					state_d = emit1_q ? ST_SEND1 : ST_IDLE;
				end
			end
			ST_SEND1: begin
				out_valid   = 1'b1;
				cmd.out_sel = 1'b1;
				last        = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/acpt_dp.sv
// Datapath: sample state, crossing test, interpolation multiply and serial divide.
`default_nettype none

module acpt_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [acpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [acpt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic signed [acpt_pkg::HEAD_W-1:0]  heading,
	input  wire logic [acpt_pkg::TIME_W-1:0]         now_us,
	input  wire acpt_pkg::cmd_t                      cmd,
	output acpt_pkg::sts_t                           sts,
	output logic [acpt_pkg::TIME_W-1:0]              pulse_time_us
);
	import acpt_pkg::*;

	// Configuration
	logic signed [HEAD_W-1:0] beacon_q;
	logic [DELAY_W-1:0]       delay_q;

	// Sample and pulse state
	logic signed [HEAD_W-1:0] heading_q;
	logic [TIME_W-1:0]        now_q;
	logic signed [HEAD_W-1:0] prev_heading_q;
	logic [TIME_W-1:0]        prev_time_q;
	logic                     have_prev_q;
	logic                     pend_valid_q;
	logic [TIME_W-1:0]        pend_time_q;
	logic [TIME_W-1:0]        first_q;

	// Arithmetic registers
	logic [MAG_W-1:0]     mag_step_q;
	logic [MAG_W-1:0]     mag_off_q;
	logic [TIME_W-1:0]    dt_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MAG_W-1:0]     rem_q;
	logic [TIME_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic signed [HEAD_W-1:0] step_w;
	logic signed [HEAD_W-1:0] off_w;
	logic signed [HEAD_W-1:0] step_abs;
	logic signed [HEAD_W-1:0] off_abs;
	logic                     range_ok;
	logic                     in_pos;
	logic                     in_neg;
	logic [TIME_W-1:0]        due_diff;
	logic [PP_W-1:0]          pp;
	logic [HALF_W-1:0]        dt_half;
	logic [MAG_W:0]           trial;
	logic                     qbit;
	logic [MAG_W-1:0]         rem_next;

	// Wrapped step and beacon offset from the previous heading
	always_comb begin
		step_w   = heading_q - prev_heading_q;
		off_w    = beacon_q - prev_heading_q;
		step_abs = step_w[HEAD_W-1] ? -step_w : step_w;
		off_abs  = off_w[HEAD_W-1] ? -off_w : off_w;
		range_ok = (step_w != 16'sd0) && (step_w < QUARTER_TURN) && (step_w > -QUARTER_TURN);
		in_pos   = !step_w[HEAD_W-1] && !off_w[HEAD_W-1] && (off_w < step_w);
		in_neg   = step_w[HEAD_W-1] && (off_w <= 16'sd0) && (off_w > step_w);
	end

	// Due test: wrapped distance past the pulse time below half range
	assign due_diff = now_q - pend_time_q;

	always_comb begin
		sts.due_now   = !due_diff[TIME_W-1];
		sts.pend_due  = pend_valid_q && !due_diff[TIME_W-1];
		sts.hit       = have_prev_q && (!pend_valid_q || !due_diff[TIME_W-1])
			&& range_ok && (in_pos || in_neg);
		sts.div_last  = (cnt_q == DIV_LAST);
	end

	// One 14x24 partial product, shared by both halves of dt
	assign dt_half = cmd.mul_hi ? dt_q[TIME_W-1:HALF_W] : dt_q[HALF_W-1:0];
	assign pp      = {{HALF_W{1'b0}}, mag_off_q} * {{MAG_W{1'b0}}, dt_half};

	// Restoring divide, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[TIME_W-1]};
		qbit  = (trial >= {1'b0, mag_step_q});
		rem_next = qbit ? MAG_W'(trial - {1'b0, mag_step_q}) : trial[MAG_W-1:0];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beacon_q <= '0;
			delay_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BEACON: beacon_q <= cfg_data[HEAD_W-1:0];
				REG_DELAY:  delay_q  <= cfg_data[DELAY_W-1:0];
				default:    ;
			endcase
		end
	end

	// Sample history and pending pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_heading_q <= '0;
			prev_time_q    <= '0;
			have_prev_q    <= 1'b0;
			pend_valid_q   <= 1'b0;
			pend_time_q    <= '0;
		end else begin
			if (cmd.store_prev) begin
				prev_heading_q <= heading_q;
				prev_time_q    <= now_q;
				have_prev_q    <= 1'b1;
			end
			if (cmd.sum_base) begin
				pend_time_q <= prev_time_q + quo_q;
			end
			if (cmd.sum_delay) begin
				pend_time_q  <= pend_time_q + {{(TIME_W-DELAY_W){1'b0}}, delay_q};
				pend_valid_q <= 1'b1;
			end
			if (cmd.take_pend || cmd.take_new) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Input word capture and interpolation operands
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			heading_q <= heading;
			now_q     <= now_us;
		end
		if (cmd.eval) begin
			mag_step_q <= step_abs[MAG_W-1:0];
			mag_off_q  <= off_abs[MAG_W-1:0];
			dt_q       <= now_q - prev_time_q;
			first_q    <= pend_time_q;
		end
	end

	// Product |offset| * dt, then quotient by |step|
	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			prod_q <= {{(PROD_W-PP_W){1'b0}}, pp};
		end else if (cmd.mul_hi) begin
			prod_q <= prod_q + {pp, {HALF_W{1'b0}}};
		end
		if (cmd.div_init) begin
			rem_q <= prod_q[PROD_W-1:TIME_W];
			quo_q <= prod_q[TIME_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[TIME_W-2:0], qbit};
		end
	end

	// Divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// First word is a pending pulse that came due, second is the new pulse
	assign pulse_time_us = cmd.out_sel ? pend_time_q : first_q;

endmodule

`default_nettype wire

### rtl/core/angle_crossing_pulse_timer.sv
// Top level of the angle crossing pulse timer.
//
//   channel   signals                         direction
//   in        in_valid/in_ready, heading,     sample word in
//             now_us
//   out       out_valid/out_ready,            pulse word out
//             pulse_time_us, last
//   cfg       cfg_we, cfg_index, cfg_data     register write, no handshake
//
// One sample at a time. A sample with no new crossing is evaluated, then its
// words (if any) are offered; one with a crossing first passes through the
// two-pass 14x24 multiplier and the 48-step serial divider. Each pulse word then
// holds the output until taken; out_ready stalls delay the next sample.
// Reset clears history, pending pulse and both registers at once; no sweep.
`default_nettype none

module angle_crossing_pulse_timer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [acpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [acpt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [acpt_pkg::HEAD_W-1:0]  heading,
	input  wire logic [acpt_pkg::TIME_W-1:0]         now_us,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [acpt_pkg::TIME_W-1:0]              pulse_time_us,
	output logic                                     last
);
	import acpt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	acpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last      (last),
		.sts       (sts),
		.cmd       (cmd)
	);

	acpt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.heading       (heading),
		.now_us        (now_us),
		.cmd           (cmd),
		.sts           (sts),
		.pulse_time_us (pulse_time_us)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the angle crossing pulse timer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import acpt_pkg::*;

	localparam int SETTLE_CYCLES = 120;
	localparam int PHASE_SAMPLES = 150;
	localparam int NUM_SETTINGS  = 8;

	typedef struct packed {
		logic [HEAD_W-1:0] hd;
		logic [TIME_W-1:0] ts;
	} sample_t;

	typedef struct packed {
		logic [TIME_W-1:0] pulse_time;
		logic              is_last;
	} pulse_word_t;

	// DUT signals
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_BEACON;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [HEAD_W-1:0] heading = '0;
	logic [TIME_W-1:0]        now_us = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [TIME_W-1:0]        pulse_time_us;
	logic                     pulse_last;

	// Predictor copy of the registers and state
	logic signed [HEAD_W-1:0] cfg_beacon = '0;
	logic [DELAY_W-1:0]       cfg_delay = '0;
	logic signed [HEAD_W-1:0] prev_head = '0;
	logic [TIME_W-1:0]        prev_time = '0;
	logic                     have_prev = 1'b0;
	logic                     pend_valid = 1'b0;
	logic [TIME_W-1:0]        pend_time = '0;

	sample_t     sample_q[$];
	pulse_word_t awaited_pulses[$];

	// Stimulus generator position
	logic signed [HEAD_W-1:0] gen_head = '0;
	logic [TIME_W-1:0]        gen_time = '0;

	int  n_queued = 0;
	int  n_samples = 0;
	int  n_words = 0;
	int  n_errors = 0;
	int  n_settings = 0;
	bit  in_fired = 1'b0;

	angle_crossing_pulse_timer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.heading      (heading),
		.now_us       (now_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pulse_time_us(pulse_time_us),
		.last         (pulse_last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// A pulse is due once the wrapped distance from it to now is under half the range
	function automatic bit pulse_ripe(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] at);
		logic [TIME_W-1:0] d;
		d = now - at;
		return !d[TIME_W-1];
	endfunction

	// Work out the pulse words one heading sample causes and queue them
	function automatic void predict_beacon_pulses(input logic signed [HEAD_W-1:0] hd,
			input logic [TIME_W-1:0] now);
		pulse_word_t       words[$];
		pulse_word_t       w;
		logic signed [HEAD_W-1:0] step;
		logic signed [HEAD_W-1:0] offset;
		int                s;
		int                o;
		int                mag_step;
		int                mag_off;
		logic [TIME_W-1:0] dt;
		logic [63:0]       part;
		logic [TIME_W-1:0] crossing;
		bit                hit;
		hit = 1'b0;
		if (pend_valid && pulse_ripe(now, pend_time)) begin
			w.pulse_time = pend_time;
			w.is_last = 1'b0;
			words.push_back(w);
			pend_valid = 1'b0;
		end
		if (!have_prev) begin
			have_prev = 1'b1;
		end else begin
			step = hd - prev_head;
			offset = cfg_beacon - prev_head;
			s = int'(step);
			o = int'(offset);
			// Search only with no pulse pending and a step under a quarter turn
			if (!pend_valid && s != 0 && s < int'(QUARTER_TURN) && s > -int'(QUARTER_TURN)) begin
				if (s > 0)
					hit = (o >= 0) && (o < s);
				else
					hit = (o <= 0) && (o > s);
			end
			if (hit) begin
				mag_step = (s < 0) ? -s : s;
				mag_off = (o < 0) ? -o : o;
				dt = now - prev_time;
				part = (64'(mag_off) * 64'(dt)) / 64'(mag_step);
				crossing = prev_time + part[TIME_W-1:0];
				pend_time = crossing + TIME_W'(cfg_delay);
				pend_valid = 1'b1;
				if (pulse_ripe(now, pend_time)) begin
					w.pulse_time = pend_time;
					w.is_last = 1'b0;
					words.push_back(w);
					pend_valid = 1'b0;
				end
			end
		end
		prev_head = hd;
		prev_time = now;
		foreach (words[i]) begin
			w = words[i];
			w.is_last = (i == words.size() - 1);
			awaited_pulses.push_back(w);
		end
	endfunction

	task automatic add_sample(input logic signed [HEAD_W-1:0] hd, input logic [TIME_W-1:0] ts);
		sample_t smp;
		smp.hd = hd;
		smp.ts = ts;
		sample_q.push_back(smp);
		n_queued++;
	endtask

	// Register write; only called with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_BEACON)
			cfg_beacon = data[HEAD_W-1:0];
		else
			cfg_delay = data[DELAY_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every sample to be taken and every word to arrive, then let the core settle
	task automatic wait_until_quiet();
		while (n_samples != n_queued || awaited_pulses.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sweeps, dithering around the beacon, broken sweeps and raw noise
	task automatic queue_random_samples(input int count, input int dt_max);
		int made;
		int kind;
		int len;
		int dir;
		int r;
		int mag;
		made = 0;
		while (made < count) begin
			kind = $urandom_range(0, 19);
			len = $urandom_range(8, 40);
			dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
			r = $urandom_range(1, 2500);
			if ($urandom_range(0, 7) == 0)
				gen_time = '1 - TIME_W'($urandom_range(0, 30 * dt_max));
			if (kind < 2) begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					add_sample(HEAD_W'($urandom()), TIME_W'({$urandom(), $urandom()}));
			end else begin
				for (int i = 0; i < len; i++) begin
					mag = ($urandom_range(0, 9) == 0) ? $urandom_range(2000, 16383)
						: $urandom_range(1, 2000);
					gen_time = gen_time + TIME_W'($urandom_range(1, dt_max));
					if (kind < 7) begin
						// back and forth across the beacon
						gen_head = cfg_beacon + HEAD_W'(int'($urandom_range(0, 2 * r)) - r);
					end else if (kind < 10) begin
						case ($urandom_range(0, 7))
							0: gen_head = gen_head + HEAD_W'(16384 * dir);
							1: gen_head = gen_head + HEAD_W'(32768);
							2: ; // heading held still
							3: begin
								gen_head = gen_head + HEAD_W'(dir * mag);
								gen_time = gen_time - TIME_W'($urandom_range(1, 2 * dt_max));
							end
							4: begin
								gen_head = gen_head + HEAD_W'(dir * mag);
								gen_time = TIME_W'({$urandom(), $urandom()});
							end
							default: gen_head = gen_head + HEAD_W'(dir * mag);
						endcase
					end else begin
						gen_head = gen_head + HEAD_W'(dir * mag);
					end
					add_sample(gen_head, gen_time);
				end
			end
			made += len;
		end
	endtask

	// Sender: bursts of words with random gaps, holding each word until taken
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin : drive_samples
		sample_t smp;
		if (arst_n && !(in_valid && !in_fired)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (sample_q.size() != 0) begin
				smp = sample_q.pop_front();
				in_valid <= 1'b1;
				heading <= smp.hd;
				now_us <= smp.ts;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern switching between modes
	int rx_mode = 0;
	int rx_mode_left = 0;
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(10, 150);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Monitor: check pulse words first, then predict from an accepted sample
	always @(posedge clk) begin : watch_ports
		pulse_word_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_pulses.size() == 0) begin
					$display("%0t ns: unexpected pulse word, expected none, got time %0d last %0d",
						$time, pulse_time_us, pulse_last);
					n_errors++;
				end else begin
					w = awaited_pulses.pop_front();
					if (pulse_time_us !== w.pulse_time) begin
						$display("%0t ns: pulse_time_us mismatch, expected %0d, got %0d",
							$time, w.pulse_time, pulse_time_us);
						n_errors++;
					end
					if (pulse_last !== w.is_last) begin
						$display("%0t ns: last mismatch, expected %0d, got %0d",
							$time, w.is_last, pulse_last);
						n_errors++;
					end
					n_words++;
				end
			end
			in_fired = in_valid && in_ready;
			if (in_fired) begin
				predict_beacon_pulses(heading, now_us);
				n_samples++;
			end
		end
	end

	initial begin
		#4000000;
		$display("Timeout with %0d pulse words still awaited", awaited_pulses.size());
		$display("== FAIL ==");
		$finish;
	end

	// Main sequence: reset, then one phase per register setting
	initial begin : run_phases
		int beacon_set[NUM_SETTINGS];
		int delay_set[NUM_SETTINGS];
		beacon_set = '{0, -32768, 32767, 16384, int'($urandom_range(0, 65535)) - 32768,
			int'($urandom_range(0, 65535)) - 32768, -16384, int'($urandom_range(0, 65535)) - 32768};
		delay_set = '{0, 1048575, 1, 40, int'($urandom_range(0, 5000)),
			int'($urandom_range(0, 1048575)), 700000, int'($urandom_range(0, 1048575))};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			write_reg(REG_BEACON, CFG_DATA_W'(beacon_set[p] & 16'hFFFF));
			write_reg(REG_DELAY, CFG_DATA_W'(delay_set[p]));
			n_settings++;
			if (p == 0) begin
				// Directed: extreme headings and times, half turn, zero step,
				// both spin directions, quarter-turn edges, backwards and wrapping time
				add_sample(-16'sd32768, '0);
				add_sample(16'sd32767, '1);
				add_sample(-16'sd1, 48'd10);
				add_sample(-16'sd1, 48'd20);
				add_sample(16'sd100, 48'd1020);
				add_sample(-16'sd200, 48'd2020);
				add_sample(16'sd0, 48'd2100);
				add_sample(16'sd16383, 48'd3100);
				add_sample(-16'sd1, 48'd4100);
				add_sample(16'sd16383, 48'd5100);
				add_sample(-16'sd1, 48'd4000);
				add_sample(-16'sd3000, 48'd3500);
				add_sample(16'sd3000, 48'd1500);
				add_sample(-16'sd3000, 48'hFFFF_FFFF_FF00);
				add_sample(16'sd3000, 48'h0000_0000_0100);
				add_sample(-16'sd3000, 48'h0000_0000_0200);
				gen_head = -16'sd3000;
				gen_time = 48'h0000_0000_0200;
			end
			queue_random_samples(PHASE_SAMPLES, delay_set[p] / 3 + 1500);
			wait_until_quiet();
		end
		$display("Checked %0d pulse words from %0d heading samples over %0d register settings",
			n_words, n_samples, n_settings);
		$display("Settings spanned beacon extremes and delays from 0 to full range");
		if (n_errors == 0 && awaited_pulses.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d pulse words never arrived", n_errors,
				awaited_pulses.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/acpt_pkg.sv
rtl/core/acpt_ctrl.sv
rtl/core/acpt_dp.sv
rtl/core/angle_crossing_pulse_timer.sv
tb/tb_top.sv
